// File: hdl/dts_pkg.sv
package dts_pkg;

   localparam int unsigned MAX_LEN = 65535;
   localparam int unsigned POS_W   = 16;
   localparam int unsigned CSR_W   = 64;
   localparam int unsigned IDX_W   = 3;

   localparam logic [POS_W-1:0] MAX_POS   = POS_W'(MAX_LEN);
   localparam logic [POS_W-1:0] COUNT_TOP = '1;

   typedef enum logic [IDX_W-1:0] {
      CSR_DELIM_LOW,
      CSR_DELIM_HIGH,
      CSR_IGNORE_LOW,
      CSR_IGNORE_HIGH,
      CSR_MAX_TOKENS
   } csr_index_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_string;
   } in_word_type;

   typedef struct packed {
      logic [63:0] delim_low;
      logic [63:0] delim_high;
      logic [63:0] ignore_low;
      logic [63:0] ignore_high;
      logic [15:0] max_tokens;
   } cfg_type;

   typedef struct packed {
      logic [15:0] token_start;
      logic [15:0] token_length;
      logic [15:0] token_index;
      logic        last_token;
      logic        overflow;
   } token_type;

   function automatic logic in_set(input logic [63:0] lo, input logic [63:0] hi,
                                   input logic [7:0] c);
      logic hit;
      if (c[7]) begin
         hit = 1'b0;
      end else if (c[6]) begin
         hit = hi[c[5:0]];
      end else begin
         hit = lo[c[5:0]];
      end
      return hit;
   endfunction

endpackage

// File: hdl/dts_csr.sv
module dts_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [dts_pkg::IDX_W-1:0]   csr_index,
   input  logic [dts_pkg::CSR_W-1:0]   csr_write_data,
   output dts_pkg::cfg_type            cfg
);

   dts_pkg::cfg_type cfg_ff;
   dts_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            dts_pkg::CSR_DELIM_LOW:   cfg_in.delim_low   = csr_write_data;
            dts_pkg::CSR_DELIM_HIGH:  cfg_in.delim_high  = csr_write_data;
            dts_pkg::CSR_IGNORE_LOW:  cfg_in.ignore_low  = csr_write_data;
            dts_pkg::CSR_IGNORE_HIGH: cfg_in.ignore_high = csr_write_data;
            dts_pkg::CSR_MAX_TOKENS:  cfg_in.max_tokens  = csr_write_data[15:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/dts_in_stage.sv
module dts_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dts_pkg::in_word_type req_word,
   input  logic                 out_ready,
   output logic                 fire,
   output dts_pkg::in_word_type word
);

   logic                 valid_ff;
   logic                 valid_in;
   dts_pkg::in_word_type word_ff;
   logic                 accept;

   assign req_stall = valid_ff & ~out_ready;
   assign accept    = req_valid & ~req_stall;
   assign fire      = valid_ff & out_ready;
   assign valid_in  = accept | (valid_ff & ~out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= req_word;
      end
   end

   assign word = word_ff;

endmodule

// File: hdl/dts_core.sv
module dts_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  dts_pkg::in_word_type word,
   input  dts_pkg::cfg_type     cfg,
   output logic                 load,
   output dts_pkg::token_type   result,
   output logic                 in_span,
   output logic                 stopped
);

   logic [15:0] position_ff, position_in;
   logic [15:0] begin_ff, begin_in;
   logic [15:0] count_ff, count_in;
   logic        span_ff, span_in;
   logic [7:0]  close_ff, close_in;
   logic        stop_ff, stop_in;
   logic        ovf_ff, ovf_in;
   logic        at_max;
   logic        is_delim;
   logic        is_ignore;

   assign at_max    = position_ff >= dts_pkg::MAX_POS;
   assign is_delim  = dts_pkg::in_set(cfg.delim_low, cfg.delim_high, word.char_code);
   assign is_ignore = dts_pkg::in_set(cfg.ignore_low, cfg.ignore_high, word.char_code);

   always_comb begin
      position_in = position_ff;
      begin_in    = begin_ff;
      count_in    = count_ff;
      span_in     = span_ff;
      close_in    = close_ff;
      stop_in     = stop_ff;
      ovf_in      = ovf_ff;
      load        = 1'b0;
      result.token_start  = begin_ff;
      result.token_length = position_ff - begin_ff;
      result.token_index  = count_ff;
      result.last_token   = 1'b1;
      result.overflow     = ovf_ff;
      if (fire) begin
         if (word.end_of_string) begin
            load        = 1'b1;
            position_in = '0;
            begin_in    = '0;
            count_in    = '0;
            span_in     = 1'b0;
            close_in    = '0;
            stop_in     = 1'b0;
            ovf_in      = 1'b0;
         end else begin
            if (at_max) begin
               position_in = dts_pkg::MAX_POS;
               ovf_in      = 1'b1;
            end else begin
               position_in = position_ff + 16'd1;
            end
            if (stop_ff) begin
               stop_in = 1'b1;
            end else if (span_ff) begin
               if (word.char_code == close_ff) begin
                  span_in = 1'b0;
               end
            end else if (is_delim) begin
               load              = 1'b1;
               result.last_token = 1'b0;
               result.overflow   = ovf_in;
               begin_in = at_max ? dts_pkg::MAX_POS : position_ff + 16'd1;
               count_in = (count_ff != dts_pkg::COUNT_TOP) ? count_ff + 16'd1 : count_ff;
               if (cfg.max_tokens != '0 && count_in == cfg.max_tokens) begin
                  stop_in = 1'b1;
               end
            end else if (is_ignore) begin
               span_in  = 1'b1;
               close_in = word.char_code;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         begin_ff    <= '0;
         count_ff    <= '0;
         span_ff     <= 1'b0;
         close_ff    <= '0;
         stop_ff     <= 1'b0;
         ovf_ff      <= 1'b0;
      end else begin
         position_ff <= position_in;
         begin_ff    <= begin_in;
         count_ff    <= count_in;
         span_ff     <= span_in;
         close_ff    <= close_in;
         stop_ff     <= stop_in;
         ovf_ff      <= ovf_in;
      end
   end

   assign in_span = span_ff;
   assign stopped = stop_ff;

endmodule

// File: hdl/dts_out_stage.sv
module dts_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  dts_pkg::token_type result,
   output logic               out_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output dts_pkg::token_type rsp_word
);

   logic               valid_ff;
   logic               valid_in;
   dts_pkg::token_type word_ff;

   assign out_ready = ~valid_ff | ~rsp_stall;
   assign valid_in  = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// File: hdl/delimited_token_splitter_top.sv
// A token word reaches rsp_valid by way of the input register, then the result
// register, after the byte or end marker that closes it is accepted; a stalled
// result can hold that byte there. Throughput: one input word per cycle, as the
// core updates state per fired word; only a stalled result holds the input.
// Reset (synchronous, active high) clears the token state, both handshakes and
// all configuration registers.
module delimited_token_splitter_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_char_code,
   input  logic                      req_end_of_string,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [15:0]               rsp_token_start,
   output logic [15:0]               rsp_token_length,
   output logic [15:0]               rsp_token_index,
   output logic                      rsp_last_token,
   output logic                      rsp_overflow,
   input  logic                      csr_write_enable,
   input  logic [dts_pkg::IDX_W-1:0] csr_index,
   input  logic [dts_pkg::CSR_W-1:0] csr_write_data
);

   dts_pkg::cfg_type     cfg;
   dts_pkg::in_word_type req_word;
   dts_pkg::in_word_type word;
   dts_pkg::token_type   result;
   dts_pkg::token_type   rsp_word;
   logic                 out_ready;
   logic                 fire;
   logic                 load;
   logic                 in_span;
   logic                 stopped;

   assign req_word.char_code     = req_char_code;
   assign req_word.end_of_string = req_end_of_string;

   dts_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   dts_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .out_ready (out_ready),
      .fire      (fire),
      .word      (word)
   );

   dts_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .word    (word),
      .cfg     (cfg),
      .load    (load),
      .result  (result),
      .in_span (in_span),
      .stopped (stopped)
   );

   dts_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .result    (result),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_token_start  = rsp_word.token_start;
   assign rsp_token_length = rsp_word.token_length;
   assign rsp_token_index  = rsp_word.token_index;
   assign rsp_last_token   = rsp_word.last_token;
   assign rsp_overflow     = rsp_word.overflow;

`ifndef SYNTHESIS
   a_eos_emits_last: assert property (@(posedge clock) disable iff (reset)
      fire && word.end_of_string |=> rsp_valid && rsp_last_token)
      else $error("end marker did not produce a final token");

   a_token_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_token_start} + {1'b0, rsp_token_length})
                    <= 17'(dts_pkg::MAX_LEN))
      else $error("token runs past the saturated length");

   a_span_not_stopped: assert property (@(posedge clock) disable iff (reset)
      !(in_span && stopped))
      else $error("quote span open after token limit reached");
`endif

endmodule

// File: tb/token_checker.sv
`timescale 1ns / 100ps

module token_checker
   import dts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [7:0]        req_char_code,
   input  logic              req_end_of_string,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [15:0]       rsp_token_start,
   input  logic [15:0]       rsp_token_length,
   input  logic [15:0]       rsp_token_index,
   input  logic              rsp_last_token,
   input  logic              rsp_overflow,
   input  logic              csr_write_enable,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]  csr_write_data,
   output int unsigned       fail_count,
   output int unsigned       pending
);

   logic [63:0] delim_low;
   logic [63:0] delim_high;
   logic [63:0] quote_low;
   logic [63:0] quote_high;
   logic [15:0] token_limit;

   logic [15:0] position;
   logic [15:0] token_begin;
   logic [15:0] token_count;
   logic        in_span;
   logic [7:0]  span_close;
   logic        stopped;
   logic        overflowed;

   token_type expected_tokens[$];

   function automatic logic member(input logic [63:0] lo, input logic [63:0] hi,
                                   input logic [7:0] c);
      logic [127:0] map;
      map = {hi, lo};
      return !c[7] && map[c[6:0]];
   endfunction

   function automatic token_type make_token(input logic [15:0] stop, input logic last);
      token_type t;
      t.token_start  = token_begin;
      t.token_length = stop - token_begin;
      t.token_index  = token_count;
      t.last_token   = last;
      t.overflow     = overflowed;
      return t;
   endfunction

   task automatic clear_string();
      position    = '0;
      token_begin = '0;
      token_count = '0;
      in_span     = 1'b0;
      span_close  = '0;
      stopped     = 1'b0;
      overflowed  = 1'b0;
   endtask

   task automatic advance_tokenizer(input logic [7:0] c, input logic eos);
      logic [15:0] here;
      if (eos) begin
         expected_tokens = {expected_tokens, make_token(position, 1'b1)};
         clear_string();
      end else begin
         here = position;
         if (position == MAX_POS) begin
            overflowed = 1'b1;
         end else begin
            position = position + 16'd1;
         end
         if (!stopped) begin
            if (in_span) begin
               if (c == span_close) begin
                  in_span = 1'b0;
               end
            end else if (member(delim_low, delim_high, c)) begin
               expected_tokens = {expected_tokens, make_token(here, 1'b0)};
               token_begin = (here == MAX_POS) ? MAX_POS : here + 16'd1;
               if (token_count != COUNT_TOP) begin
                  token_count = token_count + 16'd1;
               end
               if (token_limit != '0 && token_count == token_limit) begin
                  stopped = 1'b1;
               end
            end else if (member(quote_low, quote_high, c)) begin
               in_span    = 1'b1;
               span_close = c;
            end
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_token(input token_type got);
      token_type want;
      if (expected_tokens.size() == 0) begin
         $error("token with nothing pending: start %0d length %0d index %0d",
                got.token_start, got.token_length, got.token_index);
         fail_count++;
      end else begin
         want = expected_tokens.pop_front();
         compare_field("token_start", want.token_start, got.token_start);
         compare_field("token_length", want.token_length, got.token_length);
         compare_field("token_index", want.token_index, got.token_index);
         compare_field("last_token", 16'(want.last_token), 16'(got.last_token));
         compare_field("overflow", 16'(want.overflow), 16'(got.overflow));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         delim_low   = '0;
         delim_high  = '0;
         quote_low   = '0;
         quote_high  = '0;
         token_limit = '0;
         clear_string();
         expected_tokens.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DELIM_LOW:   delim_low   = csr_write_data;
               CSR_DELIM_HIGH:  delim_high  = csr_write_data;
               CSR_IGNORE_LOW:  quote_low   = csr_write_data;
               CSR_IGNORE_HIGH: quote_high  = csr_write_data;
               CSR_MAX_TOKENS:  token_limit = csr_write_data[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            check_token({rsp_token_start, rsp_token_length, rsp_token_index,
                         rsp_last_token, rsp_overflow});
         end
         if (req_valid && !req_stall) begin
            advance_tokenizer(req_char_code, req_end_of_string);
         end
      end
      pending = expected_tokens.size();
   end

endmodule

// File: tb/tb_delimited_token_splitter_top.sv
`timescale 1ns / 100ps

module tb_delimited_token_splitter_top
   import dts_pkg::*;
();

   localparam int unsigned DRAIN_CYCLES   = 4;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned PHASE_WORDS    = 112;

   localparam logic [IDX_W-1:0] CSR_SPARE = IDX_W'(5);

   localparam byte unsigned NUL      = 8'h00;
   localparam byte unsigned SPACE    = 8'h20;
   localparam byte unsigned DQUOTE   = 8'h22;
   localparam byte unsigned COMMA    = 8'h2c;
   localparam byte unsigned BACKTICK = 8'h60;
   localparam byte unsigned DEL      = 8'h7f;

   logic              clock             = 1'b0;
   logic              reset             = 1'b1;
   logic              req_valid         = 1'b0;
   logic              req_stall;
   logic [7:0]        req_char_code     = '0;
   logic              req_end_of_string = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall         = 1'b0;
   logic [15:0]       rsp_token_start;
   logic [15:0]       rsp_token_length;
   logic [15:0]       rsp_token_index;
   logic              rsp_last_token;
   logic              rsp_overflow;
   logic              csr_write_enable  = 1'b0;
   logic [IDX_W-1:0]  csr_index         = '0;
   logic [CSR_W-1:0]  csr_write_data    = '0;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned stuck_cycles = 0;

   bit          burst        = 1'b0;
   bit          hold_request = 1'b0;
   byte unsigned delim_pool[4];
   byte unsigned quote_pool[2];

   always #5 clock = ~clock;

   delimited_token_splitter_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_token_start   (rsp_token_start),
      .rsp_token_length  (rsp_token_length),
      .rsp_token_index   (rsp_token_index),
      .rsp_last_token    (rsp_last_token),
      .rsp_overflow      (rsp_overflow),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   token_checker check_inst (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_token_start   (rsp_token_start),
      .rsp_token_length  (rsp_token_length),
      .rsp_token_index   (rsp_token_index),
      .rsp_last_token    (rsp_last_token),
      .rsp_overflow      (rsp_overflow),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // hold off on request, otherwise draw a wait per token word
   initial begin : receiver
      int  gap;
      int  calm_left;
      bit  calm;
      calm_left = 0;
      calm      = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         if (calm_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            calm_left = 20;
         end
         calm_left--;
         gap = calm ? 0 : $urandom_range(0, 10);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_word(input logic [7:0] c, input logic eos);
      int gap;
      gap = (burst || hold_request) ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_char_code     <= c;
      req_end_of_string <= eos;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic send_string(input byte unsigned text[$]);
      burst = ($urandom_range(0, 3) == 0);
      foreach (text[i]) begin
         send_word(text[i], 1'b0);
      end
      send_word(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // drop valid, wait out every pending token and the pipeline
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] index, input logic [CSR_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic load_config(input logic [127:0] delims, input logic [127:0] quotes,
                              input logic [15:0] limit);
      settle();
      write_reg(CSR_DELIM_LOW, delims[63:0]);
      write_reg(CSR_DELIM_HIGH, delims[127:64]);
      write_reg(CSR_IGNORE_LOW, quotes[63:0]);
      write_reg(CSR_IGNORE_HIGH, quotes[127:64]);
      write_reg(CSR_MAX_TOKENS, {$urandom, 16'($urandom), limit});
      write_reg(CSR_SPARE, {$urandom, $urandom});
      csr_write_enable <= 1'b0;
   endtask

   function automatic byte unsigned pick_byte();
      byte unsigned c;
      case ($urandom_range(0, 9))
         0, 1, 2: c = delim_pool[$urandom_range(0, 3)];
         3:       c = quote_pool[$urandom_range(0, 1)];
         4:       c = 8'($urandom_range(128, 255));
         5:       c = 8'($urandom_range(0, 255));
         default: c = 8'($urandom_range(0, 127));
      endcase
      return c;
   endfunction

   initial begin : stimulus
      byte unsigned text[$];
      logic [127:0] delims;
      logic [127:0] quotes;
      logic [15:0]  limit;
      int           words;
      int           len;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      delims = '0;
      quotes = '0;
      delims[NUL]      = 1'b1;
      delims[SPACE]    = 1'b1;
      delims[COMMA]    = 1'b1;
      delims[DEL]      = 1'b1;
      quotes[DQUOTE]   = 1'b1;
      quotes[BACKTICK] = 1'b1;
      quotes[COMMA]    = 1'b1;
      load_config(delims, quotes, '0);
      text = {};
      send_string(text);
      text = '{COMMA, 8'h61, DQUOTE, BACKTICK, COMMA, DQUOTE, 8'h62, NUL, 8'hff, 8'h80,
               DEL, BACKTICK, SPACE};
      send_string(text);
      load_config(delims, quotes, 16'd1);
      text = '{COMMA, COMMA, 8'h78};
      send_string(text);

      for (int phase = 0; phase < 10; phase++) begin
         foreach (delim_pool[i]) delim_pool[i] = 8'($urandom_range(0, 127));
         foreach (quote_pool[i]) quote_pool[i] = 8'($urandom_range(0, 127));
         delims = '0;
         quotes = '0;
         foreach (delim_pool[i]) delims[delim_pool[i]] = 1'b1;
         foreach (quote_pool[i]) quotes[quote_pool[i]] = 1'b1;
         if (phase % 3 == 2) begin
            delims |= {$urandom, $urandom, $urandom, $urandom} &
                       {$urandom, $urandom, $urandom, $urandom};
            quotes |= {$urandom, $urandom, $urandom, $urandom} &
                       {$urandom, $urandom, $urandom, $urandom};
         end
         case (phase)
            0:       begin delims = '1; quotes = '1; limit = '0; end
            1:       begin delims = '0; quotes = '0; limit = '1; end
            2, 9:    limit = 16'd1;
            3:       limit = 16'd2;
            5:       limit = 16'd3;
            6:       limit = 16'($urandom_range(4, 12));
            8:       limit = 16'($urandom_range(0, 65535));
            default: limit = '0;
         endcase
         load_config(delims, quotes, limit);

         if (phase == 4) begin
            hold_request = 1'b1;
         end

         words = 0;
         while (words < PHASE_WORDS) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 60)
                                                : $urandom_range(0, 12);
            text = {};
            repeat (len) text = {text, pick_byte()};
            send_string(text);
            words += len + 1;
         end
      end

      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/dts_pkg.sv
hdl/dts_csr.sv
hdl/dts_in_stage.sv
hdl/dts_core.sv
hdl/dts_out_stage.sv
hdl/delimited_token_splitter_top.sv
tb/token_checker.sv
tb/tb_delimited_token_splitter_top.sv
